### rtl/icsr_pkg.sv
// Shared types and constants for the integer ceiling square root core.
package icsr_pkg;

    // Widths fixed by the external fields.
    localparam int RADICAND_W = 64;
    localparam int ROOT_W     = 33;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture a new radicand, clear root and remainder
        logic step;   // resolve one root bit
        logic fix;    // apply the round-up and load the result register
    } icsr_cmd_t;

endpackage

### rtl/integer_ceiling_square_root_core.sv
// Top level of the integer ceiling square root core.
//
// Returns the smallest r with r*r >= radicand for the low WIDTH bits of each
// accepted radicand (0 and 1 come back unchanged). The floor root is resolved
// by a restoring digit-by-digit loop, one root bit per cycle, followed by a
// round-up step that adds one unless the remainder is zero. A new word is
// taken in the round-up state of the previous one, once the output side can
// take that result, so no word is accepted while the root bits are resolved;
// the result register holds one finished word while the next is computed.
module integer_ceiling_square_root_core
    import icsr_pkg::*;
#(
    parameter int WIDTH = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [RADICAND_W-1:0] radicand,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ROOT_W-1:0]     root_ceiling
);

    icsr_cmd_t cmd;

    icsr_controller #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    icsr_datapath #(
        .WIDTH (WIDTH)
    ) u_dp (
        .clk          (clk),
        .cmd          (cmd),
        .radicand     (radicand),
        .root_ceiling (root_ceiling)
    );

endmodule

### rtl/icsr_datapath.sv
// Datapath: restoring square root, one root bit per step, plus round-up.
module icsr_datapath
    import icsr_pkg::*;
#(
    parameter int WIDTH = 64
)
(
    input  logic                  clk,
    input  icsr_cmd_t             cmd,
    input  logic [RADICAND_W-1:0] radicand,
    output logic [ROOT_W-1:0]     root_ceiling
);

    localparam int RW  = (WIDTH + 1) / 2;   // root bits
    localparam int RDW = 2 * RW;            // padded radicand bits
    localparam int RMW = RW + 1;            // remainder bits, holds up to 2*root
    localparam int TW  = RW + 3;            // trial width

    logic [RDW-1:0]    rad_reg, rad_next;
    logic [RMW-1:0]    rem_reg, rem_next;
    logic [RW-1:0]     root_reg, root_next;
    logic [ROOT_W-1:0] res_reg, res_next;

    logic [TW-1:0] rem_sh;
    logic [TW-1:0] trial;
    logic [TW-1:0] diff;
    logic          take;

    always_comb
    begin
        rem_sh = {rem_reg, rad_reg[RDW-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        diff   = rem_sh - trial;
        take   = (rem_sh >= trial);

        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        res_next  = res_reg;

        if (cmd.load)
        begin
            rad_next  = RDW'(radicand[WIDTH-1:0]);
            rem_next  = '0;
            root_next = '0;
        end
        else if (cmd.step)
        begin
            // Pull in the next two radicand bits and try setting a root bit.
            rad_next  = rad_reg << 2;
            rem_next  = take ? diff[RMW-1:0] : rem_sh[RMW-1:0];
            root_next = RW'({root_reg, take});
        end

        // Round up unless the floor root is exact.
        if (cmd.fix)
        begin
            res_next = ROOT_W'({1'b0, root_reg} + (RW + 1)'(rem_reg != '0));
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        res_reg  <= res_next;
    end

    assign root_ceiling = res_reg;

endmodule

### rtl/icsr_controller.sv
// Controller: sequences load, root steps and round-up, and owns the handshakes.
module icsr_controller
    import icsr_pkg::*;
#(
    parameter int WIDTH = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output icsr_cmd_t cmd
);

    localparam int RW    = (WIDTH + 1) / 2;
    localparam int CNT_W = $clog2(RW + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIX
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             fix_ok;
    logic             accept;

    always_comb
    begin
        fix_ok   = !out_valid_reg || out_ready;
        in_ready = (state_reg == ST_IDLE) || ((state_reg == ST_FIX) && fix_ok);
        accept   = in_valid && in_ready;

        cmd.load = accept;
        cmd.step = (state_reg == ST_RUN);
        cmd.fix  = (state_reg == ST_FIX) && fix_ok;

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.fix)
        begin
            out_valid_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    cnt_next   = CNT_W'(RW - 1);
                end
            end
            ST_RUN:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIX;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_FIX:
            begin
                // Hold while the previous word still waits at the output.
                if (accept)
                begin
                    state_next = ST_RUN;
                    cnt_next   = CNT_W'(RW - 1);
                end
                else if (fix_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_load_step_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.step}))
        else $error("load and step issued together");

    a_step_fix_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.step && cmd.fix))
        else $error("step and fix issued together");

    a_fix_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fix |=> out_valid)
        else $error("result not presented after fix");

    a_load_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_RUN) && (cnt_reg == CNT_W'(RW - 1)))
        else $error("accepted word did not start the root steps");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) && (cnt_reg == '0) |=> (state_reg == ST_FIX))
        else $error("root steps did not end in round-up");

endmodule
